FILE: hw/rtl/ata_pio_sector_sequencer_unit_defines.svh
// assertion macros for the ata pio sector sequencer
// used by ata_pio_sector_sequencer_unit; expects clock and reset in scope
`ifndef ATA_PIO_SECTOR_SEQUENCER_UNIT_DEFINES_SVH
`define ATA_PIO_SECTOR_SEQUENCER_UNIT_DEFINES_SVH

// check that is off while reset is high
`define APSS_CHECK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also holds during reset
`define APSS_CHECK_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: hw/rtl/apss_pkg.sv
// types, codes and helpers for the ata pio sector sequencer
// no dependencies; imported by ata_pio_sector_sequencer_unit
package apss_pkg;

   localparam int WORDS_PER_SECTOR = 256;
   localparam int DELAY_READS      = 4;
   localparam int MAX_RES          = 6;
   localparam int CNT_W            = $clog2(MAX_RES + 1);
   localparam int WORD_W           = $clog2(WORDS_PER_SECTOR + 1);
   localparam int DELAY_W          = $clog2(DELAY_READS + 1);
   localparam int POLL_W           = 20;

   localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 20'd100000;

   // input kinds
   localparam logic [1:0] KIND_CMD   = 2'd0;
   localparam logic [1:0] KIND_RESP  = 2'd1;
   localparam logic [1:0] KIND_WDATA = 2'd2;

   // command ops
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   // result kinds
   localparam logic [1:0] OUT_BUS_READ  = 2'd0;
   localparam logic [1:0] OUT_BUS_WRITE = 2'd1;
   localparam logic [1:0] OUT_HOST      = 2'd2;
   localparam logic [1:0] OUT_DONE      = 2'd3;

   // task file registers
   localparam logic [3:0] REG_DATA   = 4'd0;
   localparam logic [3:0] REG_ERROR  = 4'd1;
   localparam logic [3:0] REG_COUNT  = 4'd2;
   localparam logic [3:0] REG_LBA0   = 4'd3;
   localparam logic [3:0] REG_LBA1   = 4'd4;
   localparam logic [3:0] REG_LBA2   = 4'd5;
   localparam logic [3:0] REG_DRIVE  = 4'd6;
   localparam logic [3:0] REG_CMD    = 4'd7;
   localparam logic [3:0] REG_ALT    = 4'd8;
   localparam logic [3:0] REG_NONE   = 4'd0;

   // done codes
   localparam logic [1:0] DONE_OK    = 2'd0;
   localparam logic [1:0] DONE_IO    = 2'd1;
   localparam logic [1:0] DONE_PARAM = 2'd2;

   // config register indexes
   localparam logic CSR_DEVICE_PRESENT = 1'b0;
   localparam logic CSR_POLL_LIMIT     = 1'b1;

   // status bits and register values
   localparam int ST_BSY  = 7;
   localparam int ST_DRDY = 6;
   localparam int ST_DRQ  = 3;
   localparam int ST_ERR  = 0;

   localparam logic [7:0] SEL_MASTER = 8'hA0;
   localparam logic [7:0] SEL_SLAVE  = 8'hB0;
   localparam logic [7:0] LBA_MODE   = 8'h40;
   localparam logic [7:0] ATA_READ   = 8'h20;
   localparam logic [7:0] ATA_WRITE  = 8'h30;
   localparam logic [7:0] ATA_FLUSH  = 8'hE7;

   typedef enum logic [4:0] {
      PH_IDLE,
      PH_RDY_BSY,
      PH_RDY_DRDY,
      PH_SEL_DELAY,
      PH_CMD_DELAY,
      PH_DRQ_BSY,
      PH_DRQ_WAIT,
      PH_RD_DATA,
      PH_WR_DATA,
      PH_WR_BSY,
      PH_STAT,
      PH_ERRREG,
      PH_FL_BSY,
      PH_FL_DRDY,
      PH_FL_SEL_DELAY,
      PH_FL_CMD_DELAY,
      PH_FL_END_BSY,
      PH_FL_END_DRDY
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  op;
      logic [27:0] lba;
      logic [7:0]  count;
      logic        use_slave;
      logic [15:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [3:0]  reg_select;
      logic [15:0] out_data;
      logic [1:0]  done_code;
      logic        last;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [1:0] knd, input logic [3:0] sel,
                                        input logic [15:0] data, input logic [1:0] code);
      rsp_type r;
      r.out_kind   = knd;
      r.reg_select = sel;
      r.out_data   = data;
      r.done_code  = code;
      r.last       = 1'b0;
      return r;
   endfunction

   function automatic rsp_type bus_read(input logic [3:0] sel);
      return make_rsp(OUT_BUS_READ, sel, 16'h0000, DONE_OK);
   endfunction

   function automatic rsp_type bus_write(input logic [3:0] sel, input logic [7:0] byte_val);
      return make_rsp(OUT_BUS_WRITE, sel, {8'h00, byte_val}, DONE_OK);
   endfunction

   function automatic rsp_type cmd_done(input logic [1:0] code, input logic [7:0] err_val);
      return make_rsp(OUT_DONE, REG_NONE, {8'h00, err_val}, code);
   endfunction

endpackage

FILE: hw/rtl/ata_pio_sector_sequencer_unit.sv
// ata pio lba28 read, write and flush sequencer over a task-file bus
// depends on apss_pkg and ata_pio_sector_sequencer_unit_defines.svh
`include "ata_pio_sector_sequencer_unit_defines.svh"

// An accepted item waits in an input register until the queue is free, then
// the sequencer decodes it against the current phase and loads all of its
// results (zero to six) into a result queue at once; the queue hands them out
// one per cycle while rsp_ready is high, the last one flagged. A new item is
// taken every cycle as long as each item causes at most one result and
// rsp_ready stays high: host write words flow at one per cycle. An item with
// several results holds the next item until its last result is taken, as the
// result port moves one result per cycle. Every bus read result must be answered by
// one read-response item before the sequence goes on. There is no clearing pass after reset.
module ata_pio_sector_sequencer_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  apss_pkg::req_type         req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output apss_pkg::rsp_type         rsp_data,
   input  logic                      csr_we,
   input  logic                      csr_index,
   input  logic [19:0]               csr_wdata
);
   import apss_pkg::*;

   // config
   logic                 device_present_ff;
   logic [POLL_W-1:0]    poll_limit_ff;

   // input stage
   logic                 in_valid_ff, in_valid_in;
   req_type              in_ff;

   // sequencer state
   phase_type            phase_ff, phase_in;
   logic [POLL_W-1:0]    poll_count_ff, poll_count_in;
   logic [1:0]           cmd_op_ff, cmd_op_in;
   logic [27:0]          target_lba_ff, target_lba_in;
   logic [7:0]           sectors_left_ff, sectors_left_in;
   logic [WORD_W-1:0]    word_index_ff, word_index_in;
   logic [DELAY_W-1:0]   delay_count_ff, delay_count_in;
   logic                 drive_is_slave_ff, drive_is_slave_in;

   // result queue
   rsp_type              res_ff [MAX_RES];
   rsp_type              res_in [MAX_RES];
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   rsp_type              lst_c  [MAX_RES];
   logic [CNT_W-1:0]     num_c;

   logic                 q_free;
   logic                 proc_fire;
   logic [7:0]           st;
   logic [POLL_W-1:0]    lim;
   logic                 lim_hit;
   logic                 bsy_go, drdy_go;
   logic                 delay_more;
   logic [WORD_W-1:0]    wi_inc;
   logic                 wi_more;
   logic                 sect_more;
   logic                 op_bad;
   logic [7:0]           sel_byte;

   // handshake
   assign q_free    = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_ready);
   assign proc_fire = in_valid_ff && q_free;
   assign req_ready = !in_valid_ff || q_free;
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = res_ff[0];

   // shared decode terms
   assign st         = in_ff.value[7:0];
   assign lim        = (poll_limit_ff == '0) ? POLL_W'(1) : poll_limit_ff;
   assign lim_hit    = (poll_count_ff >= lim);
   assign bsy_go     = !st[ST_BSY] || lim_hit;
   assign drdy_go    = st[ST_DRDY] || lim_hit;
   assign delay_more = (delay_count_ff < DELAY_W'(DELAY_READS));
   assign wi_inc     = word_index_ff + WORD_W'(1);
   assign wi_more    = (wi_inc < WORD_W'(WORDS_PER_SECTOR));
   assign sect_more  = (sectors_left_ff != 8'd1);
   assign op_bad     = (in_ff.op != OP_READ) && (in_ff.op != OP_WRITE)
                       && (in_ff.op != OP_FLUSH);
   assign sel_byte   = drive_is_slave_ff ? SEL_SLAVE : SEL_MASTER;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (proc_fire) begin
         in_valid_in = 1'b0;
      end
   end

   // next state
   always_comb begin
      phase_in          = phase_ff;
      poll_count_in     = poll_count_ff;
      cmd_op_in         = cmd_op_ff;
      target_lba_in     = target_lba_ff;
      sectors_left_in   = sectors_left_ff;
      word_index_in     = word_index_ff;
      delay_count_in    = delay_count_ff;
      drive_is_slave_in = drive_is_slave_ff;
      if (proc_fire) begin
         case (in_ff.kind)
            KIND_CMD: begin
               if (phase_ff == PH_IDLE && device_present_ff && !op_bad
                   && !(in_ff.op != OP_FLUSH && in_ff.count == 8'd0)) begin
                  cmd_op_in         = in_ff.op;
                  target_lba_in     = in_ff.lba;
                  sectors_left_in   = in_ff.count;
                  drive_is_slave_in = in_ff.use_slave;
                  word_index_in     = '0;
                  poll_count_in     = POLL_W'(1);
                  phase_in          = (in_ff.op == OP_FLUSH) ? PH_FL_BSY : PH_RDY_BSY;
               end
            end
            KIND_WDATA: begin
               if (phase_ff == PH_WR_DATA) begin
                  word_index_in = wi_inc;
                  if (!wi_more) begin
                     phase_in      = PH_WR_BSY;
                     poll_count_in = POLL_W'(1);
                  end
               end
            end
            KIND_RESP: begin
               case (phase_ff)
                  PH_RDY_BSY, PH_DRQ_BSY, PH_FL_BSY, PH_FL_END_BSY: begin
                     if (bsy_go) begin
                        poll_count_in = POLL_W'(1);
                        case (phase_ff)
                           PH_RDY_BSY: phase_in = PH_RDY_DRDY;
                           PH_DRQ_BSY: phase_in = PH_DRQ_WAIT;
                           PH_FL_BSY:  phase_in = PH_FL_DRDY;
                           default:    phase_in = PH_FL_END_DRDY;
                        endcase
                     end else begin
                        poll_count_in = poll_count_ff + POLL_W'(1);
                     end
                  end
                  PH_RDY_DRDY, PH_FL_DRDY: begin
                     if (drdy_go) begin
                        delay_count_in = DELAY_W'(1);
                        phase_in = (phase_ff == PH_RDY_DRDY) ? PH_SEL_DELAY : PH_FL_SEL_DELAY;
                     end else begin
                        poll_count_in = poll_count_ff + POLL_W'(1);
                     end
                  end
                  PH_SEL_DELAY, PH_FL_SEL_DELAY: begin
                     if (delay_more) begin
                        delay_count_in = delay_count_ff + DELAY_W'(1);
                     end else begin
                        delay_count_in = DELAY_W'(1);
                        phase_in = (phase_ff == PH_SEL_DELAY) ? PH_CMD_DELAY : PH_FL_CMD_DELAY;
                     end
                  end
                  PH_CMD_DELAY, PH_FL_CMD_DELAY: begin
                     if (delay_more) begin
                        delay_count_in = delay_count_ff + DELAY_W'(1);
                     end else begin
                        poll_count_in = POLL_W'(1);
                        phase_in = (phase_ff == PH_CMD_DELAY) ? PH_DRQ_BSY : PH_FL_END_BSY;
                     end
                  end
                  PH_DRQ_WAIT: begin
                     if (st[ST_DRQ]) begin
                        word_index_in = '0;
                        phase_in = (cmd_op_ff == OP_WRITE) ? PH_WR_DATA : PH_RD_DATA;
                     end else if (st[ST_ERR] || lim_hit) begin
                        phase_in = PH_IDLE;
                     end else begin
                        poll_count_in = poll_count_ff + POLL_W'(1);
                     end
                  end
                  PH_RD_DATA: begin
                     word_index_in = wi_inc;
                     if (!wi_more) begin
                        phase_in = PH_STAT;
                     end
                  end
                  PH_WR_BSY: begin
                     if (bsy_go) begin
                        phase_in = PH_STAT;
                     end else begin
                        poll_count_in = poll_count_ff + POLL_W'(1);
                     end
                  end
                  PH_STAT: begin
                     if (st[ST_ERR]) begin
                        phase_in = PH_ERRREG;
                     end else begin
                        sectors_left_in = sectors_left_ff - 8'd1;
                        if (sect_more) begin
                           poll_count_in = POLL_W'(1);
                           phase_in      = PH_DRQ_BSY;
                        end else if (cmd_op_ff == OP_WRITE && device_present_ff) begin
                           poll_count_in = POLL_W'(1);
                           phase_in      = PH_FL_BSY;
                        end else begin
                           phase_in = PH_IDLE;
                        end
                     end
                  end
                  PH_ERRREG: begin
                     phase_in = PH_IDLE;
                  end
                  PH_FL_END_DRDY: begin
                     if (drdy_go) begin
                        phase_in = PH_IDLE;
                     end else begin
                        poll_count_in = poll_count_ff + POLL_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
            default: begin
            end
         endcase
      end
   end

   // results of the item in the input register
   always_comb begin
      for (int i = 0; i < MAX_RES; i++) begin
         lst_c[i] = bus_read(REG_NONE);
      end
      num_c = '0;
      case (in_ff.kind)
         KIND_CMD: begin
            if (phase_ff == PH_IDLE) begin
               if (!device_present_ff || op_bad) begin
                  lst_c[0] = cmd_done(DONE_PARAM, 8'h00);
               end else if (in_ff.op != OP_FLUSH && in_ff.count == 8'd0) begin
                  lst_c[0] = cmd_done(DONE_OK, 8'h00);
               end else begin
                  lst_c[0] = bus_read(REG_CMD);
               end
               num_c = CNT_W'(1);
            end
         end
         KIND_WDATA: begin
            if (phase_ff == PH_WR_DATA) begin
               lst_c[0] = make_rsp(OUT_BUS_WRITE, REG_DATA, in_ff.value, DONE_OK);
               num_c    = CNT_W'(1);
               if (!wi_more) begin
                  lst_c[1] = bus_read(REG_CMD);
                  num_c    = CNT_W'(2);
               end
            end
         end
         KIND_RESP: begin
            case (phase_ff)
               PH_RDY_BSY, PH_DRQ_BSY, PH_FL_BSY, PH_FL_END_BSY, PH_WR_BSY: begin
                  lst_c[0] = bus_read(REG_CMD);
                  num_c    = CNT_W'(1);
               end
               PH_RDY_DRDY, PH_FL_DRDY: begin
                  if (drdy_go) begin
                     if (phase_ff == PH_RDY_DRDY) begin
                        lst_c[0] = bus_write(REG_DRIVE,
                                             sel_byte | LBA_MODE | {4'h0, target_lba_ff[27:24]});
                     end else begin
                        lst_c[0] = bus_write(REG_DRIVE, sel_byte);
                     end
                     lst_c[1] = bus_read(REG_ALT);
                     num_c    = CNT_W'(2);
                  end else begin
                     lst_c[0] = bus_read(REG_CMD);
                     num_c    = CNT_W'(1);
                  end
               end
               PH_SEL_DELAY: begin
                  if (delay_more) begin
                     lst_c[0] = bus_read(REG_ALT);
                     num_c    = CNT_W'(1);
                  end else begin
                     lst_c[0] = bus_write(REG_COUNT, sectors_left_ff);
                     lst_c[1] = bus_write(REG_LBA0, target_lba_ff[7:0]);
                     lst_c[2] = bus_write(REG_LBA1, target_lba_ff[15:8]);
                     lst_c[3] = bus_write(REG_LBA2, target_lba_ff[23:16]);
                     lst_c[4] = bus_write(REG_CMD,
                                          (cmd_op_ff == OP_WRITE) ? ATA_WRITE : ATA_READ);
                     lst_c[5] = bus_read(REG_ALT);
                     num_c    = CNT_W'(6);
                  end
               end
               PH_FL_SEL_DELAY: begin
                  if (delay_more) begin
                     lst_c[0] = bus_read(REG_ALT);
                     num_c    = CNT_W'(1);
                  end else begin
                     lst_c[0] = bus_write(REG_CMD, ATA_FLUSH);
                     lst_c[1] = bus_read(REG_ALT);
                     num_c    = CNT_W'(2);
                  end
               end
               PH_CMD_DELAY, PH_FL_CMD_DELAY: begin
                  lst_c[0] = delay_more ? bus_read(REG_ALT) : bus_read(REG_CMD);
                  num_c    = CNT_W'(1);
               end
               PH_DRQ_WAIT: begin
                  if (st[ST_DRQ]) begin
                     if (cmd_op_ff != OP_WRITE) begin
                        lst_c[0] = bus_read(REG_DATA);
                        num_c    = CNT_W'(1);
                     end
                  end else if (st[ST_ERR] || lim_hit) begin
                     lst_c[0] = cmd_done(DONE_IO, 8'h00);
                     num_c    = CNT_W'(1);
                  end else begin
                     lst_c[0] = bus_read(REG_CMD);
                     num_c    = CNT_W'(1);
                  end
               end
               PH_RD_DATA: begin
                  lst_c[0] = make_rsp(OUT_HOST, REG_NONE, in_ff.value, DONE_OK);
                  lst_c[1] = wi_more ? bus_read(REG_DATA) : bus_read(REG_CMD);
                  num_c    = CNT_W'(2);
               end
               PH_STAT: begin
                  if (st[ST_ERR]) begin
                     lst_c[0] = bus_read(REG_ERROR);
                  end else if (sect_more || (cmd_op_ff == OP_WRITE && device_present_ff)) begin
                     lst_c[0] = bus_read(REG_CMD);
                  end else begin
                     lst_c[0] = cmd_done(DONE_OK, 8'h00);
                  end
                  num_c = CNT_W'(1);
               end
               PH_ERRREG: begin
                  lst_c[0] = cmd_done(DONE_IO, st);
                  num_c    = CNT_W'(1);
               end
               PH_FL_END_DRDY: begin
                  lst_c[0] = drdy_go ? cmd_done(DONE_OK, 8'h00) : bus_read(REG_CMD);
                  num_c    = CNT_W'(1);
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
      if (num_c != '0) begin
         lst_c[num_c - CNT_W'(1)].last = 1'b1;
      end
   end

   // result queue: load on decode, shift on take
   always_comb begin
      res_in = res_ff;
      cnt_in = cnt_ff;
      if (proc_fire) begin
         res_in = lst_c;
         cnt_in = num_c;
      end else if (rsp_valid && rsp_ready) begin
         for (int i = 0; i < MAX_RES - 1; i++) begin
            res_in[i] = res_ff[i + 1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_present_ff <= 1'b0;
         poll_limit_ff     <= POLL_LIMIT_RESET;
         in_valid_ff       <= 1'b0;
         phase_ff          <= PH_IDLE;
         poll_count_ff     <= '0;
         cmd_op_ff         <= '0;
         target_lba_ff     <= '0;
         sectors_left_ff   <= '0;
         word_index_ff     <= '0;
         delay_count_ff    <= '0;
         drive_is_slave_ff <= 1'b0;
         cnt_ff            <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DEVICE_PRESENT: device_present_ff <= csr_wdata[0];
               CSR_POLL_LIMIT:     poll_limit_ff     <= csr_wdata[POLL_W-1:0];
               default: begin
               end
            endcase
         end
         in_valid_ff       <= in_valid_in;
         phase_ff          <= phase_in;
         poll_count_ff     <= poll_count_in;
         cmd_op_ff         <= cmd_op_in;
         target_lba_ff     <= target_lba_in;
         sectors_left_ff   <= sectors_left_in;
         word_index_ff     <= word_index_in;
         delay_count_ff    <= delay_count_in;
         drive_is_slave_ff <= drive_is_slave_in;
         cnt_ff            <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      res_ff <= res_in;
   end

   // a decoded item with results shows a result next cycle
   `APSS_CHECK(a_load_shows, proc_fire && (num_c != '0) |=> rsp_valid, "results lost on load")
   // command done always closes its item and leaves the sequencer idle
   `APSS_CHECK(a_done_idle, rsp_valid && (rsp_data.out_kind == OUT_DONE) |-> rsp_data.last && (phase_ff == PH_IDLE), "done result while busy")
   // word counter stays inside the sector while moving data
   `APSS_CHECK(a_word_range, (phase_ff == PH_RD_DATA) || (phase_ff == PH_WR_DATA) |-> word_index_ff < WORD_W'(WORDS_PER_SECTOR), "word index past sector")
   // a held input item means results are still queued
   `APSS_CHECK_ALWAYS(a_hold_queued, !reset && in_valid_ff && !req_ready |-> cnt_ff != '0, "input stalled with empty queue")

endmodule
